@@ rtl/core/htfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the CRC-8 byte update of the frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam int unsigned QueueDepthDef = 4;

  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  localparam logic [14:0] TempScale  = 15'd17500;
  localparam logic [14:0] HumScale   = 15'd12500;
  localparam logic [14:0] TempOffset = 15'h7FFF - 15'd4499;
  localparam logic [14:0] HumOffset  = 15'h7FFF - 15'd599;
  localparam logic [30:0] RoundHalf  = 31'd32767;

  localparam int unsigned ProdWidth = 31;

  typedef struct packed {
    logic [15:0] word;
    logic        is_hum;
    logic        pass;
  } htfd_entry_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/htfd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_front
// Tracks the byte position, runs the CRC and queues one request per word.
// ----------------------------------------------------------------------------
module htfd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           rx_byte_i,
  input  logic                 frame_start_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output htfd_pkg::htfd_entry_t push_data_o
);
  import htfd_pkg::*;

  localparam logic [2:0] PosTempHi  = 3'd0;
  localparam logic [2:0] PosTempLo  = 3'd1;
  localparam logic [2:0] PosTempCrc = 3'd2;
  localparam logic [2:0] PosHumHi   = 3'd3;
  localparam logic [2:0] PosHumLo   = 3'd4;
  localparam logic [2:0] PosHumCrc  = 3'd5;

  logic [2:0]  pos_q;
  logic [2:0]  pos;
  logic [7:0]  crc_q;
  logic [7:0]  hi_q;
  logic [15:0] word_q;
  logic        accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    pos = frame_start_i ? PosTempHi : pos_q;
    if (pos > PosHumCrc) begin
      pos = PosTempHi;
    end
  end

  assign push_o             = accept && (pos == PosTempCrc || pos == PosHumCrc);
  assign push_data_o.word   = word_q;
  assign push_data_o.is_hum = (pos == PosHumCrc);
  assign push_data_o.pass   = (crc_q == rx_byte_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= PosTempHi;
      crc_q  <= CrcInit;
      hi_q   <= '0;
      word_q <= '0;
    end else if (accept) begin
      case (pos)
        PosTempHi, PosHumHi: begin
          crc_q <= crc_byte(CrcInit, rx_byte_i);
          hi_q  <= rx_byte_i;
          pos_q <= pos + 3'd1;
        end
        PosTempLo, PosHumLo: begin
          crc_q  <= crc_byte(crc_q, rx_byte_i);
          word_q <= {hi_q, rx_byte_i};
          pos_q  <= pos + 3'd1;
        end
        PosTempCrc: begin
          pos_q <= PosHumHi;
        end
        default: begin
          pos_q <= PosTempHi;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/htfd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_fifo
// Short request queue between the byte front end and the conversion back end.
// ----------------------------------------------------------------------------
module htfd_fifo #(
  parameter int unsigned Depth = htfd_pkg::QueueDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  htfd_pkg::htfd_entry_t push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output htfd_pkg::htfd_entry_t pop_data_o
);
  import htfd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  htfd_entry_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q;
  logic [PtrW-1:0]     rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push;
  logic                do_pop;

  assign full_o     = (count_q == FullCnt);
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("Queue count exceeds its depth.");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("Request pushed into a full queue.");
`endif

endmodule

@@ rtl/core/htfd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_back
// Scales checked words to fixed point, holds the values and forms the result.
// ----------------------------------------------------------------------------
module htfd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  htfd_pkg::htfd_entry_t q_data_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [14:0]    temperature_centi_o,
  output logic signed [14:0]    humidity_centi_o,
  output logic                  temperature_ok_o,
  output logic                  humidity_ok_o
);
  import htfd_pkg::*;

  logic                 en;
  logic                 s1_valid_q;
  logic                 s1_hum_q;
  logic                 s1_pass_q;
  logic [ProdWidth-1:0] s1_prod_q;
  logic [ProdWidth-1:0] prod_d;
  logic [ProdWidth-1:0] m;
  logic [ProdWidth-1:0] t;
  logic [14:0]          q;
  logic [14:0]          value;
  logic [14:0]          held_temp_q;
  logic [14:0]          held_hum_q;
  logic                 temp_ok_q;
  logic                 out_valid_q;
  logic                 load_out;

  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && q_valid_i;

  assign prod_d = ProdWidth'(q_data_i.word * (q_data_i.is_hum ? HumScale : TempScale));

  // The quotient by 65535 stays below 2^16, so a shift with one add is exact.
  assign m     = s1_prod_q + RoundHalf;
  assign t     = m + ProdWidth'(m[ProdWidth-1:16]) + ProdWidth'(1);
  assign q     = t[30:16];
  assign value = (s1_hum_q ? HumOffset : TempOffset) + q;

  assign load_out = en && s1_valid_q && s1_hum_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_prod_q <= prod_d;
      s1_hum_q  <= q_data_i.is_hum;
      s1_pass_q <= q_data_i.pass;
    end
    if (load_out) begin
      temperature_centi_o <= held_temp_q;
      humidity_centi_o    <= s1_pass_q ? value : held_hum_q;
      temperature_ok_o    <= temp_ok_q;
      humidity_ok_o       <= s1_pass_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      held_temp_q <= '0;
      held_hum_q  <= '0;
      temp_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= q_valid_i;
      out_valid_q <= load_out;
      if (s1_valid_q && s1_pass_q) begin
        if (s1_hum_q) begin
          held_hum_q <= value;
        end else begin
          held_temp_q <= value;
        end
      end
      if (s1_valid_q && !s1_hum_q) begin
        temp_ok_q <= s1_pass_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_result_from_hum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(s1_valid_q && s1_hum_q))
    else $error("Result raised without a humidity request.");

  a_stall_holds_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(s1_valid_q) && $stable(held_temp_q))
    else $error("Conversion stage moved while the result was stalled.");
`endif

endmodule

@@ rtl/core/humidity_temp_frame_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Decodes the six-byte temperature and humidity response into fixed point.
// ----------------------------------------------------------------------------
// The input channel takes one response byte per request with a start flag
// that marks the first byte of a frame. The output channel carries one
// request per complete frame with both held values and both check flags.
// Bytes are accepted at one per cycle unless the queue is full. The front
// end checks the CRC of each word and queues one request per word; the back
// end multiplies the word by its scale into a product register, then
// rescales and rounds it into the held values and output registers.
// When the receiver stalls, the back end holds and the queue of QueueDepth
// requests fills; input ready drops only once the queue is full.
// Reset clears the byte position, the held values and all pending requests.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder #(
  parameter int unsigned QueueDepth = htfd_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [14:0] temperature_centi_o,
  output logic signed [14:0] humidity_centi_o,
  output logic               temperature_ok_o,
  output logic               humidity_ok_o
);
  import htfd_pkg::*;

  logic        push;
  htfd_entry_t push_data;
  logic        q_full;
  logic        pop;
  logic        q_valid;
  htfd_entry_t q_data;

  htfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  htfd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  htfd_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_valid_i           (q_valid),
    .q_data_i            (q_data),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .temperature_centi_o (temperature_centi_o),
    .humidity_centi_o    (humidity_centi_o),
    .temperature_ok_o    (temperature_ok_o),
    .humidity_ok_o       (humidity_ok_o)
  );

endmodule

@@ tb/humidity_temp_frame_decoder_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_check
// Predicts and checks the readings of the frame decoder.
// ----------------------------------------------------------------------------
// Watches both channels of the decoder. Every accepted byte advances a model
// of the frame position, the CRC of the current word and the held values;
// the last byte of a frame queues the reading that the decoder must send.
// Every accepted reading is compared field by field with the oldest queued
// one. The number of failures and of readings still due go to the top.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder_check (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              frame_start_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic signed [14:0] temperature_centi_i,
  input  logic signed [14:0] humidity_centi_i,
  input  logic              temperature_ok_i,
  input  logic              humidity_ok_i,
  output int                err_count_o,
  output int                pending_o
);

  localparam int unsigned TempSpan = 17500;
  localparam int          TempBase = -4500;
  localparam int unsigned HumSpan  = 12500;
  localparam int          HumBase  = -600;
  localparam longint unsigned FullScale = 65535;

  typedef enum logic [2:0] {
    PosTempHigh,
    PosTempLow,
    PosTempCrc,
    PosHumHigh,
    PosHumLow,
    PosHumCrc
  } frame_pos_e;

  typedef struct {
    logic signed [14:0] temp;
    logic signed [14:0] hum;
    logic               temp_ok;
    logic               hum_ok;
  } reading_t;

  frame_pos_e  pos_q;
  logic [7:0]  crc_q;
  logic [7:0]  high_q;
  logic [15:0] word_q;
  logic        temp_pass_q;
  logic [14:0] held_temp_q;
  logic [14:0] held_hum_q;
  reading_t    expected_readings[$];

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ htfd_pkg::CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // Offset plus the scaled word rounded to nearest, as a 15-bit pattern.
  function automatic logic [14:0] convert_word(input logic [15:0] raw,
                                               input int unsigned span, input int base);
    longint unsigned q;
    int              v;
    q = (64'd2 * span * raw + FullScale) / (64'd2 * FullScale);
    v = base + int'(q);
    return v[14:0];
  endfunction

  task automatic report_failure(input string msg);
    $display("mismatch: %s", msg);
    err_count_o++;
  endtask

  task automatic compare_reading();
    reading_t want;
    if (expected_readings.size() == 0) begin
      report_failure($sformatf("reading with no frame due: temp %0d hum %0d ok %0b%0b",
                               temperature_centi_i, humidity_centi_i,
                               temperature_ok_i, humidity_ok_i));
    end else begin
      want = expected_readings.pop_front();
      if (temperature_centi_i !== want.temp) begin
        report_failure($sformatf("temperature_centi got %0d expected %0d",
                                 temperature_centi_i, want.temp));
      end
      if (humidity_centi_i !== want.hum) begin
        report_failure($sformatf("humidity_centi got %0d expected %0d",
                                 humidity_centi_i, want.hum));
      end
      if (temperature_ok_i !== want.temp_ok) begin
        report_failure($sformatf("temperature_ok got %0b expected %0b",
                                 temperature_ok_i, want.temp_ok));
      end
      if (humidity_ok_i !== want.hum_ok) begin
        report_failure($sformatf("humidity_ok got %0b expected %0b",
                                 humidity_ok_i, want.hum_ok));
      end
    end
  endtask

  task automatic take_byte(input logic [7:0] b, input logic start);
    frame_pos_e p;
    reading_t   r;
    p = (start || pos_q > PosHumCrc) ? PosTempHigh : pos_q;
    case (p)
      PosTempHigh, PosHumHigh: begin
        crc_q  = crc_step(htfd_pkg::CrcInit, b);
        high_q = b;
        pos_q  = (p == PosTempHigh) ? PosTempLow : PosHumLow;
      end
      PosTempLow, PosHumLow: begin
        crc_q  = crc_step(crc_q, b);
        word_q = {high_q, b};
        pos_q  = (p == PosTempLow) ? PosTempCrc : PosHumCrc;
      end
      PosTempCrc: begin
        temp_pass_q = (crc_q == b);
        if (temp_pass_q) begin
          held_temp_q = convert_word(word_q, TempSpan, TempBase);
        end
        pos_q = PosHumHigh;
      end
      default: begin
        r.hum_ok = (crc_q == b);
        if (r.hum_ok) begin
          held_hum_q = convert_word(word_q, HumSpan, HumBase);
        end
        r.temp    = held_temp_q;
        r.hum     = held_hum_q;
        r.temp_ok = temp_pass_q;
        expected_readings.push_back(r);
        pos_q = PosTempHigh;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       = PosTempHigh;
      crc_q       = htfd_pkg::CrcInit;
      high_q      = '0;
      word_q      = '0;
      temp_pass_q = 1'b0;
      held_temp_q = '0;
      held_hum_q  = '0;
      expected_readings.delete();
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        compare_reading();
      end
      if (in_valid_i && in_ready_i) begin
        take_byte(rx_byte_i, frame_start_i);
      end
      pending_o = expected_readings.size();
    end
  end

endmodule

@@ tb/humidity_temp_frame_decoder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_test
// Testbench top of the humidity and temperature frame decoder.
// ----------------------------------------------------------------------------
// Sends a few directed frames (extreme words, failed checks, a frame with no
// start flag and a frame cut short by a new start) and then random traffic:
// mostly well-formed frames with random words and mostly good CRCs, plus cut
// frames and noise bytes. The sender works in bursts and the receiver stalls
// on its own pattern, once for long enough to back the decoder up. The
// checker beside the decoder predicts and compares the readings.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder_test;

  localparam int StallLimit  = 2000;
  localparam int HoldOff     = 400;
  localparam int RandomBytes = 600;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        rx_byte;
  logic              frame_start;
  logic              out_valid;
  logic              out_ready;
  logic signed [14:0] temp_centi;
  logic signed [14:0] hum_centi;
  logic              temp_ok;
  logic              hum_ok;
  int                err_count;
  int                pending;
  int                sent_items = 0;
  int                burst_left = 0;
  int                idle_cycles = 0;
  bit                held_off = 1'b0;
  bit                draining = 1'b0;

  humidity_temp_frame_decoder dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .rx_byte_i          (rx_byte),
    .frame_start_i      (frame_start),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .temperature_centi_o(temp_centi),
    .humidity_centi_o   (hum_centi),
    .temperature_ok_o   (temp_ok),
    .humidity_ok_o      (hum_ok)
  );

  humidity_temp_frame_decoder_check frame_check (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .rx_byte_i          (rx_byte),
    .frame_start_i      (frame_start),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .temperature_centi_i(temp_centi),
    .humidity_centi_i   (hum_centi),
    .temperature_ok_i   (temp_ok),
    .humidity_ok_i      (hum_ok),
    .err_count_o        (err_count),
    .pending_o          (pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [7:0] word_check(input logic [15:0] w);
    logic [7:0] c;
    c = htfd_pkg::CrcInit;
    for (int i = 15; i >= 0; i--) begin
      c = (c[7] ^ w[i]) ? ({c[6:0], 1'b0} ^ htfd_pkg::CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [15:0] pick_word();
    logic [15:0] edges[5];
    edges = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFE, 16'hFFFF};
    if ($urandom_range(0, 7) == 0) begin
      return edges[$urandom_range(0, 4)];
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid    <= 1'b1;
    rx_byte     <= b;
    frame_start <= start;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    burst_left--;
    sent_items++;
  endtask

  // Sends the first n bytes of a frame; a word marked bad gets a wrong CRC.
  task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                            input logic t_good, input logic h_good,
                            input logic start, input int n);
    logic [7:0] fb[6];
    fb[0] = t_raw[15:8];
    fb[1] = t_raw[7:0];
    fb[2] = word_check(t_raw) ^ (t_good ? 8'h00 : 8'($urandom_range(1, 255)));
    fb[3] = h_raw[15:8];
    fb[4] = h_raw[7:0];
    fb[5] = word_check(h_raw) ^ (h_good ? 8'h00 : 8'($urandom_range(1, 255)));
    for (int i = 0; i < n; i++) begin
      send_byte(fb[i], (i == 0) && start);
    end
  endtask

  initial begin : receiver
    int mode;
    int len;
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (!held_off && sent_items >= 150) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldOff) @(negedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(1, 40);
        for (int k = 0; k < len; k++) begin
          if (draining || mode == 0) begin
            out_ready <= 1'b1;
          end else if (mode == 1) begin
            out_ready <= ($urandom_range(0, 3) != 0);
          end else if (mode == 2) begin
            out_ready <= ($urandom_range(0, 3) == 0);
          end else begin
            out_ready <= (k % 3 == 2);
          end
          @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int kind;
    int stop_at;
    rst_n       <= 1'b0;
    in_valid    = 1'b0;
    rx_byte     = 8'h00;
    frame_start = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Temperature fails before any good word, so it still reads as zero.
    send_frame(16'hBEEF, 16'hFFFF, 1'b0, 1'b1, 1'b1, 6);
    // No start flag: the position wraps after the previous frame.
    send_frame(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0, 6);
    // A frame cut after its temperature word by the start flag of the next one.
    send_frame(16'hFFFF, 16'h6666, 1'b1, 1'b1, 1'b1, 3);
    send_frame(16'hFFFF, 16'hBEEF, 1'b1, 1'b0, 1'b1, 6);

    stop_at = sent_items + RandomBytes;
    while (sent_items < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        send_frame(pick_word(), pick_word(), $urandom_range(0, 7) != 0,
                   $urandom_range(0, 7) != 0, $urandom_range(0, 4) != 0, 6);
      end else if (kind == 7) begin
        send_frame(pick_word(), pick_word(), 1'b1, 1'b1, 1'b1, $urandom_range(1, 5));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
      end
    end

    in_valid <= 1'b0;
    draining = 1'b1;
    wait (pending == 0);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
